### rtl/core/cba_pkg.sv
// shared constants and types for the chunked bump allocator
`timescale 1ns / 1ps
package cba_pkg;

    localparam int MAX_CHUNKS = 16;
    localparam int ADDR_BITS  = 24;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int CTR_W      = 32;

    localparam logic [LEN_W-1:0]     SPACE_BYTES  = LEN_W'(1) << ADDR_BITS;
    localparam logic [LEN_W-1:0]     DEF_CHUNK    = LEN_W'(1024 * 1024);
    localparam logic [ADDR_BITS-1:0] DEF_DISCARD  = ADDR_BITS'(64);

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHUNK_SIZE = 2'd0;
    localparam logic [1:0] CFG_DISCARD    = 2'd1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 eval;
        logic                 pick;
        logic                 commit;
        logic                 carve;
        logic                 clear;
        logic                 carve_drop;
        logic [IDX_W-1:0]     carve_idx;
        logic [CNT_W-1:0]     carved;
        logic [CNT_W-1:0]     rbound;
        logic [LEN_W-1:0]     size;
        logic [ADDR_BITS-1:0] disc;
        logic [ADDR_BITS-1:0] base;
        logic [LEN_W-1:0]     len;
    } t_cell_ctl;

endpackage

### rtl/core/cba_cell.sv
// one chunk slot: bounds, use count, open flag and its link in the fit chains
`timescale 1ns / 1ps
module cba_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cba_pkg::IDX_W-1:0]     i_idx,
    input  cba_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_hi_chain,
    output logic                          o_hi_chain,
    input  logic                          i_lo_chain,
    output logic                          o_lo_chain,
    input  logic                          i_any_hi,
    output logic                          o_grant,
    output logic                          o_drop,
    output logic [cba_pkg::ADDR_BITS-1:0] o_addr
);
    import cba_pkg::*;

    logic [ADDR_BITS-1:0] r_base;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_used;
    logic                 r_open;
    logic                 r_fit;
    logic                 r_drop;
    logic                 r_grant;
    logic [LEN_W-1:0]     room;
    logic                 hi;
    logic                 live;

    assign room = r_len - r_used;
    assign hi   = {1'b0, i_idx} >= i_ctl.rbound;
    assign live = {1'b0, i_idx} < i_ctl.carved;

    // newer chunks chain from the top down, reopened ones from the bottom up
    assign o_hi_chain = i_hi_chain | (r_fit & hi);
    assign o_lo_chain = i_lo_chain | (r_fit & ~hi);

    assign o_grant = r_grant;
    assign o_drop  = r_grant & r_drop;
    assign o_addr  = r_grant ? ADDR_BITS'(r_base + r_used[ADDR_BITS-1:0]) : '0;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_fit   <= 1'b0;
            r_grant <= 1'b0;
        end else begin
            if (i_ctl.eval) begin
                r_fit   <= r_open && (room >= i_ctl.size);
                r_grant <= 1'b0;
            end
            if (i_ctl.pick) begin
                r_grant <= r_fit & (hi ? ~i_hi_chain : (~i_any_hi & ~i_lo_chain));
            end
            if (i_ctl.commit && r_grant && r_drop) begin
                r_open <= 1'b0;
            end
            if (i_ctl.carve && i_idx == i_ctl.carve_idx) begin
                r_open <= ~i_ctl.carve_drop;
            end
            if (i_ctl.clear && live) begin
                r_open <= 1'b1;
            end
        end
    end

    // chunk payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_drop <= (room - i_ctl.size) <= {1'b0, i_ctl.disc};
        end
        if (i_ctl.commit && r_grant) begin
            r_used <= r_used + i_ctl.size;
        end
        if (i_ctl.carve && i_idx == i_ctl.carve_idx) begin
            r_base <= i_ctl.base;
            r_len  <= i_ctl.len;
            r_used <= i_ctl.size;
        end
        if (i_ctl.clear && live) begin
            r_used <= '0;
        end
    end

endmodule

### rtl/core/chunked_bump_allocator.sv
// chunked bump allocator top level: sequencer, statistics and the row of chunk cells
//
// Usage:
//   input channel  (i_in_valid/o_in_ready): one beat = command + size.
//   output channel (o_out_valid/i_out_ready): one beat per input beat with
//     status, address and the pool statistics after the command.
//   config channel (i_cfg_valid/o_cfg_ready): index 0 chunk_size, index 1
//     discard_threshold; always ready, write only while the block is idle.
// Timing: an item passes through the steps accept, per-cell fit check,
//   first-fit pick along the cell chains and commit; the result beat is
//   registered at the commit. The next item is accepted only after the commit,
//   so the block takes no new item before it is through with the last one.
// The first-fit order is kept as open flags plus a boundary index: chunks
//   carved after the last effective pool reset rank newest first, older ones
//   rank oldest first after them.
// Reset: synchronous active low; empties the pool, zeroes the counters and
//   restores the register defaults. No clearing pass is needed.
// Stall: a finished result waits in the output register; the commit of the
//   following item holds until that beat has been taken.
`timescale 1ns / 1ps
module chunked_bump_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [cba_pkg::LEN_W-1:0]     i_size,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic [cba_pkg::ADDR_BITS-1:0] o_address,
    output logic [cba_pkg::CTR_W-1:0]     o_alloc_total,
    output logic [cba_pkg::CTR_W-1:0]     o_alloc_bytes_total,
    output logic [cba_pkg::CTR_W-1:0]     o_reset_total,
    output logic [cba_pkg::CNT_W-1:0]     o_chunk_total,
    output logic [cba_pkg::CNT_W-1:0]     o_open_chunk_total,
    output logic [cba_pkg::LEN_W-1:0]     o_pool_bytes,
    output logic [cba_pkg::LEN_W-1:0]     o_pool_free_bytes,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cba_pkg::LEN_W-1:0]     i_cfg_data
);
    import cba_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FIT, S_PICK, S_COMMIT} t_state;

    t_state               r_state;
    logic [1:0]           r_cmd;
    logic [LEN_W-1:0]     r_size;
    logic [LEN_W-1:0]     r_cfg_chunk;
    logic [ADDR_BITS-1:0] r_cfg_disc;
    logic [CNT_W-1:0]     r_carved;
    logic [CNT_W-1:0]     r_open_cnt;
    logic [CNT_W-1:0]     r_rbound;
    logic [LEN_W-1:0]     r_next_base;
    logic [LEN_W-1:0]     r_used_sum;
    logic [CTR_W-1:0]     r_alloc_ctr;
    logic [CTR_W-1:0]     r_byte_ctr;
    logic [CTR_W-1:0]     r_reset_ctr;
    logic [CTR_W-1:0]     r_alloc_at_reset;

    logic [CNT_W-1:0]     n_carved;
    logic [CNT_W-1:0]     n_open_cnt;
    logic [CNT_W-1:0]     n_rbound;
    logic [LEN_W-1:0]     n_next_base;
    logic [LEN_W-1:0]     n_used_sum;
    logic [CTR_W-1:0]     n_alloc_ctr;
    logic [CTR_W-1:0]     n_byte_ctr;
    logic [CTR_W-1:0]     n_reset_ctr;
    logic [CTR_W-1:0]     n_alloc_at_reset;
    logic                 n_status;
    logic [ADDR_BITS-1:0] n_address;

    t_cell_ctl            cell_ctl;
    logic [MAX_CHUNKS:0]  hi_link;
    logic [MAX_CHUNKS:0]  lo_link;
    logic [MAX_CHUNKS-1:0] grant_vec;
    logic [MAX_CHUNKS-1:0] drop_vec;
    logic [ADDR_BITS-1:0] cell_addr [MAX_CHUNKS];
    logic [ADDR_BITS-1:0] hit_addr;

    logic                 fire;
    logic                 hit;
    logic                 any_drop;
    logic [LEN_W-1:0]     chunk_eff;
    logic [ADDR_BITS-1:0] disc_eff;
    logic [LEN_W-1:0]     new_len;
    logic                 oom;
    logic                 new_drop;
    logic                 pool_reset;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign fire      = (r_state == S_COMMIT) && (!o_out_valid || i_out_ready);
    assign chunk_eff = (r_cfg_chunk == '0) ? DEF_CHUNK : r_cfg_chunk;
    assign disc_eff  = (r_cfg_disc == '0) ? DEF_DISCARD : r_cfg_disc;
    assign new_len   = (r_size > chunk_eff) ? r_size : chunk_eff;
    assign oom       = (r_carved == CNT_W'(MAX_CHUNKS)) ||
                       (new_len > (SPACE_BYTES - r_next_base));
    assign new_drop  = (new_len - r_size) <= {1'b0, disc_eff};
    assign hit       = |grant_vec;
    assign any_drop  = |drop_vec;
    assign pool_reset = (r_alloc_at_reset != r_alloc_ctr);

    // merge the granted cell's address
    always_comb begin
        hit_addr = '0;
        for (int k = 0; k < MAX_CHUNKS; k++) begin
            hit_addr = hit_addr | cell_addr[k];
        end
    end

    // broadcast to the cells
    always_comb begin
        cell_ctl            = '0;
        cell_ctl.eval       = (r_state == S_FIT);
        cell_ctl.pick       = (r_state == S_PICK);
        cell_ctl.commit     = fire && (r_cmd == CMD_ALLOC);
        cell_ctl.carve      = fire && (r_cmd == CMD_ALLOC) && !hit && !oom;
        cell_ctl.clear      = fire && (r_cmd == CMD_RESET) && pool_reset;
        cell_ctl.carve_drop = new_drop;
        cell_ctl.carve_idx  = r_carved[IDX_W-1:0];
        cell_ctl.carved     = r_carved;
        cell_ctl.rbound     = r_rbound;
        cell_ctl.size       = r_size;
        cell_ctl.disc       = disc_eff;
        cell_ctl.base       = r_next_base[ADDR_BITS-1:0];
        cell_ctl.len        = new_len;
    end

    // row of chunk cells
    assign hi_link[MAX_CHUNKS] = 1'b0;
    assign lo_link[0]          = 1'b0;
    for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
        cba_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IDX_W'(g)),
            .i_ctl      (cell_ctl),
            .i_hi_chain (hi_link[g+1]),
            .o_hi_chain (hi_link[g]),
            .i_lo_chain (lo_link[g]),
            .o_lo_chain (lo_link[g+1]),
            .i_any_hi   (hi_link[0]),
            .o_grant    (grant_vec[g]),
            .o_drop     (drop_vec[g]),
            .o_addr     (cell_addr[g])
        );
    end

    // commit of one command
    always_comb begin
        n_carved         = r_carved;
        n_open_cnt       = r_open_cnt;
        n_rbound         = r_rbound;
        n_next_base      = r_next_base;
        n_used_sum       = r_used_sum;
        n_alloc_ctr      = r_alloc_ctr;
        n_byte_ctr       = r_byte_ctr;
        n_reset_ctr      = r_reset_ctr;
        n_alloc_at_reset = r_alloc_at_reset;
        n_status         = 1'b0;
        n_address        = '0;
        case (r_cmd)
            CMD_ALLOC: begin
                if (hit || !oom) begin
                    n_alloc_ctr = r_alloc_ctr + 1'b1;
                    n_byte_ctr  = r_byte_ctr + CTR_W'(r_size);
                    n_used_sum  = r_used_sum + r_size;
                end
                if (hit) begin
                    n_address  = hit_addr;
                    n_open_cnt = r_open_cnt - CNT_W'(any_drop);
                end else if (oom) begin
                    n_status = 1'b1;
                end else begin
                    n_address   = r_next_base[ADDR_BITS-1:0];
                    n_carved    = r_carved + 1'b1;
                    n_next_base = r_next_base + new_len;
                    n_open_cnt  = r_open_cnt + CNT_W'(!new_drop);
                end
            end
            CMD_RESET: begin
                n_reset_ctr = r_reset_ctr + 1'b1;
                if (pool_reset) begin
                    n_alloc_at_reset = r_alloc_ctr;
                    n_used_sum       = '0;
                    n_open_cnt       = r_carved;
                    n_rbound         = r_carved;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer, statistics and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            o_out_valid      <= 1'b0;
            r_cfg_chunk      <= DEF_CHUNK;
            r_cfg_disc       <= DEF_DISCARD;
            r_carved         <= '0;
            r_open_cnt       <= '0;
            r_rbound         <= '0;
            r_next_base      <= '0;
            r_used_sum       <= '0;
            r_alloc_ctr      <= '0;
            r_byte_ctr       <= '0;
            r_reset_ctr      <= '0;
            r_alloc_at_reset <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_CHUNK_SIZE) begin
                    r_cfg_chunk <= i_cfg_data;
                end else if (i_cfg_index == CFG_DISCARD) begin
                    r_cfg_disc <= i_cfg_data[ADDR_BITS-1:0];
                end
            end
            if (o_out_valid && i_out_ready && !fire) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_command;
                        r_size  <= i_size;
                        r_state <= S_FIT;
                    end
                end
                S_FIT: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (fire) begin
                        r_state             <= S_IDLE;
                        r_carved            <= n_carved;
                        r_open_cnt          <= n_open_cnt;
                        r_rbound            <= n_rbound;
                        r_next_base         <= n_next_base;
                        r_used_sum          <= n_used_sum;
                        r_alloc_ctr         <= n_alloc_ctr;
                        r_byte_ctr          <= n_byte_ctr;
                        r_reset_ctr         <= n_reset_ctr;
                        r_alloc_at_reset    <= n_alloc_at_reset;
                        o_out_valid         <= 1'b1;
                        o_status            <= n_status;
                        o_address           <= n_address;
                        o_alloc_total       <= n_alloc_ctr;
                        o_alloc_bytes_total <= n_byte_ctr;
                        o_reset_total       <= n_reset_ctr;
                        o_chunk_total       <= n_carved;
                        o_open_chunk_total  <= n_open_cnt;
                        o_pool_bytes        <= n_next_base;
                        o_pool_free_bytes   <= n_next_base - n_used_sum;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // first fit never grants two chunks
    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(grant_vec))
        else $error("more than one chunk granted");

    // open list never holds more chunks than were carved
    a_open_le_carved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_cnt <= r_carved)
        else $error("open count above carved count");

    // a commit always leaves a result beat pending
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("commit without result");

    // a carve only happens with no chunk granted
    a_carve_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.carve |-> !hit)
        else $error("carve while a chunk fits");
`endif

endmodule

### tb/sv/tb_chunked_bump_allocator.sv
// self-checking testbench for the chunked bump allocator
`timescale 1ns / 1ps
module tb_chunked_bump_allocator;
    import cba_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam logic [1:0] CFG_TOP   = 2'd3;
    localparam int         MAX_SHOWN = 10;

    typedef struct packed {
        logic                 status;
        logic [ADDR_BITS-1:0] address;
        logic [CTR_W-1:0]     allocs;
        logic [CTR_W-1:0]     bytes;
        logic [CTR_W-1:0]     resets;
        logic [CNT_W-1:0]     chunks;
        logic [CNT_W-1:0]     open_chunks;
        logic [LEN_W-1:0]     pool;
        logic [LEN_W-1:0]     pool_free;
    } t_stats;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_command = CMD_QUERY;
    logic [LEN_W-1:0]     i_size = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_status;
    logic [ADDR_BITS-1:0] o_address;
    logic [CTR_W-1:0]     o_alloc_total;
    logic [CTR_W-1:0]     o_alloc_bytes_total;
    logic [CTR_W-1:0]     o_reset_total;
    logic [CNT_W-1:0]     o_chunk_total;
    logic [CNT_W-1:0]     o_open_chunk_total;
    logic [LEN_W-1:0]     o_pool_bytes;
    logic [LEN_W-1:0]     o_pool_free_bytes;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index = CFG_CHUNK_SIZE;
    logic [LEN_W-1:0]     i_cfg_data = '0;

    chunked_bump_allocator u_top (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // arena mirror
    logic [ADDR_BITS-1:0] arena_base [MAX_CHUNKS];
    logic [LEN_W-1:0]     arena_len  [MAX_CHUNKS];
    logic [LEN_W-1:0]     arena_used [MAX_CHUNKS];
    int                   open_list  [MAX_CHUNKS];
    int                   open_cnt;
    int                   carved_cnt;
    longint               next_free;
    logic [CTR_W-1:0]     alloc_ctr, byte_ctr, reset_ctr, alloc_at_clear;
    logic [LEN_W-1:0]     chunk_size_reg;
    logic [ADDR_BITS-1:0] discard_reg;

    t_stats expected_stats [$];
    int     mismatches;
    int     beats_sent, beats_checked, oom_seen, clears_seen;
    int     sender_idle_pct, sink_stall_pct;

    // bump inside the chunk at open position pos, retire it if nearly full
    function automatic bit bump_chunk(int pos, longint size, ref logic [ADDR_BITS-1:0] addr);
        int     c;
        longint room, disc;
        c    = open_list[pos];
        room = longint'(arena_len[c]) - longint'(arena_used[c]);
        if (room < size) return 1'b0;
        addr = ADDR_BITS'(longint'(arena_base[c]) + longint'(arena_used[c]));
        arena_used[c] = LEN_W'(longint'(arena_used[c]) + size);
        disc = (discard_reg != 0) ? longint'(discard_reg) : longint'(DEF_DISCARD);
        if (room - size <= disc) begin
            for (int k = pos; k + 1 < open_cnt; k++) open_list[k] = open_list[k + 1];
            open_cnt--;
        end
        alloc_ctr++;
        byte_ctr = byte_ctr + CTR_W'(size);
        return 1'b1;
    endfunction

    // apply one command to the mirror and return the statistics beat
    function automatic t_stats predict_stats(logic [1:0] cmd, logic [LEN_W-1:0] size);
        t_stats               r;
        bit                   done;
        longint               cs, len, pool, pool_free;
        logic [ADDR_BITS-1:0] addr;
        r = '0;
        done = 1'b0;
        pool = 0;
        pool_free = 0;
        addr = '0;
        if (cmd == CMD_ALLOC) begin
            for (int k = 0; k < open_cnt && !done; k++)
                done = bump_chunk(k, longint'(size), addr);
            if (!done) begin
                cs  = (chunk_size_reg != 0) ? longint'(chunk_size_reg) : longint'(DEF_CHUNK);
                len = (longint'(size) > cs) ? longint'(size) : cs;
                if (carved_cnt >= MAX_CHUNKS || len > (longint'(1) << ADDR_BITS) - next_free) begin
                    r.status = 1'b1;
                    oom_seen++;
                end else begin
                    arena_base[carved_cnt] = ADDR_BITS'(next_free);
                    arena_len[carved_cnt]  = LEN_W'(len);
                    arena_used[carved_cnt] = '0;
                    next_free += len;
                    for (int k = open_cnt; k > 0; k--) open_list[k] = open_list[k - 1];
                    open_list[0] = carved_cnt;
                    open_cnt++;
                    carved_cnt++;
                    void'(bump_chunk(0, longint'(size), addr));
                end
            end
        end else if (cmd == CMD_RESET) begin
            reset_ctr++;
            if (alloc_at_clear != alloc_ctr) begin
                alloc_at_clear = alloc_ctr;
                for (int k = 0; k < carved_cnt; k++) begin
                    arena_used[k] = '0;
                    open_list[k]  = k;
                end
                open_cnt = carved_cnt;
                clears_seen++;
            end
        end
        for (int k = 0; k < carved_cnt; k++) begin
            pool      += longint'(arena_len[k]);
            pool_free += longint'(arena_len[k]) - longint'(arena_used[k]);
        end
        r.address     = addr;
        r.allocs      = alloc_ctr;
        r.bytes       = byte_ctr;
        r.resets      = reset_ctr;
        r.chunks      = CNT_W'(carved_cnt);
        r.open_chunks = CNT_W'(open_cnt);
        r.pool        = LEN_W'(pool);
        r.pool_free   = LEN_W'(pool_free);
        return r;
    endfunction

    // receiver backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_stats got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_address, o_alloc_total, o_alloc_bytes_total, o_reset_total,
                    o_chunk_total, o_open_chunk_total, o_pool_bytes, o_pool_free_bytes};
            beats_checked++;
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat %0d: %p", beats_checked, got);
            end else begin
                want = expected_stats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("beat %0d mismatch", beats_checked);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    // send one command beat, idling first at random
    task automatic send_beat(logic [1:0] cmd, logic [LEN_W-1:0] size);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_size     <= size;
        do @(posedge i_clk); while (!o_in_ready);
        expected_stats.push_back(predict_stats(cmd, size));
        beats_sent++;
    endtask

    // drop valid and wait until every result has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register write while idle
    task automatic write_reg(logic [1:0] idx, logic [LEN_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CHUNK_SIZE) chunk_size_reg = data;
        else if (idx == CFG_DISCARD) discard_reg = data[ADDR_BITS-1:0];
    endtask

    // extremes of the fields, every command and the corner cases
    task automatic test_directed;
        send_beat(CMD_QUERY, '0);
        send_beat(CMD_RESET, '0);                  // reset with nothing allocated
        send_beat(CMD_ALLOC, '0);                  // zero size carves the first chunk
        send_beat(CMD_ALLOC, LEN_W'(1) << ADDR_BITS); // whole space, does not fit
        send_beat(CMD_ALLOC, 25'd1000);
        send_beat(CMD_ALLOC, 25'd1048000);         // too large for the first chunk, carves a second
        send_beat(CMD_ALLOC, 25'd1048576);
        send_beat(CMD_ALLOC, 25'd3000000);         // larger than a chunk
        send_beat(CMD_SPARE, '1);                  // spare code acts as a query
        send_beat(CMD_QUERY, '1);
        send_beat(CMD_RESET, '1);                  // reopens every chunk
        send_beat(CMD_RESET, '0);                  // nothing since, only counts
        send_beat(CMD_ALLOC, 25'd1);
        send_beat(CMD_ALLOC, 25'h0AAAAA);
        send_beat(CMD_ALLOC, 25'h155555);
        send_beat(CMD_ALLOC, 25'd12000000);        // runs past the end of space
        send_beat(CMD_ALLOC, 25'd0);
        send_beat(CMD_RESET, '0);
    endtask

    // registers: ignored indexes, zero values acting as defaults, the discard maximum
    task automatic test_registers;
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_TOP, 25'h0AAAAA);
        write_reg(CFG_CHUNK_SIZE, '0);
        write_reg(CFG_DISCARD, '0);
        send_beat(CMD_ALLOC, 25'd5);
        send_beat(CMD_ALLOC, 25'd2000);
        write_reg(CFG_DISCARD, '1);                // upper bit dropped, threshold at max
        send_beat(CMD_ALLOC, 25'd7);
        write_reg(CFG_CHUNK_SIZE, 25'h155555);
        send_beat(CMD_ALLOC, 25'd9);
    endtask

    // random traffic under one register setting
    task automatic test_random(logic [LEN_W-1:0] cs, logic [LEN_W-1:0] disc,
                               int send_idle, int sink_stall, int count);
        int               pick;
        logic [1:0]       cmd;
        logic [LEN_W-1:0] size;
        write_reg(CFG_CHUNK_SIZE, cs);
        write_reg(CFG_DISCARD, disc);
        sender_idle_pct = send_idle;
        sink_stall_pct  = sink_stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            cmd  = (pick < 72) ? CMD_ALLOC : (pick < 84) ? CMD_RESET :
                   (pick < 96) ? CMD_QUERY : CMD_SPARE;
            pick = $urandom_range(99);
            if (pick < 65)      size = LEN_W'($urandom_range(300));
            else if (pick < 88) size = LEN_W'($urandom_range(1 << 16));
            else if (pick < 98) size = LEN_W'($urandom_range(1 << 21));
            else                size = LEN_W'($urandom_range(1 << ADDR_BITS));
            send_beat(cmd, size);
        end
    endtask

    // hard stop
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int wait_cycles;
        arena_base = '{default: '0};
        arena_len  = '{default: '0};
        arena_used = '{default: '0};
        open_list  = '{default: 0};
        open_cnt = 0;
        carved_cnt = 0;
        next_free = 0;
        alloc_ctr = '0;
        byte_ctr = '0;
        reset_ctr = '0;
        alloc_at_clear = '0;
        chunk_size_reg = DEF_CHUNK;
        discard_reg = DEF_DISCARD;
        mismatches = 0;
        beats_sent = 0;
        beats_checked = 0;
        oom_seen = 0;
        clears_seen = 0;
        sender_idle_pct = 17;
        sink_stall_pct = 50;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_registers();
        test_random(25'd4096,       25'd1,        17, 50, 300);
        test_random(25'd0,          25'd0,        50, 17, 300);
        test_random(25'd16777216,   25'd16777215, 0,  0,  150);
        test_random(25'd1,          25'd200,      0,  0,  250);
        test_random(25'd65536,      25'd64,       0,  0,  250);

        // final drain with a bound
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_stats.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_stats.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", expected_stats.size());
        end

        $display("covered %0d command beats, %0d results checked, %0d out of memory",
                 beats_sent, beats_checked, oom_seen);
        $display("pool clears %0d, chunks carved %0d, mismatches %0d",
                 clears_seen, carved_cnt, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
